[rtl/median_line_crossing_counter_assert.svh]
// Assertion macros for the median line crossing counter.
// Needs clk and arst_n in the scope of each use.
`ifndef MEDIAN_LINE_CROSSING_COUNTER_ASSERT_SVH
`define MEDIAN_LINE_CROSSING_COUNTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MLC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mlc assertion failed");
`define MLC_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("mlc assertion failed");
`else
`define MLC_ASSERT(lbl, prop)
`define MLC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

[rtl/mlc_pkg.sv]
// Shared types and constants of the median line crossing counter.
// No dependencies.
package mlc_pkg;
	localparam int NUM_SLOTS  = 16;
	localparam int SLOT_W     = 4;
	localparam int MAX_WINDOW = 8;
	localparam int HEAD_W     = 3;
	localparam int FILL_W     = 4;
	localparam int COORD_BITS = 16;
	localparam int CNT_W      = 16;
	localparam int HOLD_W     = 8;
	localparam int FIFO_DEPTH = 2;

	localparam logic [1:0] SIDE_NEG  = 2'd0;
	localparam logic [1:0] SIDE_MID  = 2'd1;
	localparam logic [1:0] SIDE_POS  = 2'd2;
	localparam logic [1:0] SIDE_NONE = 2'd3;

	localparam logic [1:0] CROSS_NONE = 2'd0;
	localparam logic [1:0] CROSS_IN   = 2'd1;
	localparam logic [1:0] CROSS_OUT  = 2'd2;

	localparam logic [2:0] REG_LINE   = 3'd0;
	localparam logic [2:0] REG_DEAD   = 3'd1;
	localparam logic [2:0] REG_TRAVEL = 3'd2;
	localparam logic [2:0] REG_THOLD  = 3'd3;
	localparam logic [2:0] REG_GHOLD  = 3'd4;
	localparam logic [2:0] REG_WINDOW = 3'd5;
	localparam logic [2:0] REG_POLAR  = 3'd6;

	typedef struct packed {
		logic                         is_tick;
		logic [SLOT_W-1:0]            slot;
		logic signed [COORD_BITS-1:0] pos;
		logic                         new_track;
	} item_t;

	typedef struct packed {
		logic signed [15:0] line_position;
		logic [14:0]        dead_zone;
		logic [15:0]        min_travel;
		logic [HOLD_W-1:0]  track_hold;
		logic [HOLD_W-1:0]  global_hold;
		logic [3:0]         median_window;
		logic               positive_means_out;
	} cfg_t;
endpackage

[rtl/mlc_front.sv]
// Front end: accepts items, decodes them and queues them for the back end.
// Depends on mlc_pkg.
module mlc_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic [mlc_pkg::SLOT_W-1:0]         track_slot,
	input  logic signed [mlc_pkg::COORD_BITS-1:0] position,
	input  logic                               new_track,
	output logic                               q_valid,
	output mlc_pkg::item_t                     q_item,
	input  logic                               q_pop
);
	mlc_pkg::item_t ent_q [mlc_pkg::FIFO_DEPTH];
	mlc_pkg::item_t dec;
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign in_stall = (cnt_q == 2'(mlc_pkg::FIFO_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];

	always_comb begin
		dec.is_tick   = action;
		dec.slot      = action ? '0 : track_slot;
		dec.pos       = action ? '0 : position;
		dec.new_track = action ? 1'b0 : new_track;
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

[rtl/mlc_back.sv]
// Back end: slot histories, median, hysteresis, counters and result register.
// Depends on mlc_pkg and median_line_crossing_counter_assert.svh.
`include "median_line_crossing_counter_assert.svh"
module mlc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mlc_pkg::cfg_t          cfg,
	input  logic                   q_valid,
	input  mlc_pkg::item_t         q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             crossing,
	output logic [15:0]            in_total,
	output logic [15:0]            out_total,
	output logic [15:0]            occupancy,
	output logic signed [15:0]     smoothed_position,
	output logic [1:0]             side
);
	localparam int MW = mlc_pkg::MAX_WINDOW;
	localparam int HW = mlc_pkg::HEAD_W;
	localparam int FW = mlc_pkg::FILL_W;
	localparam int CB = mlc_pkg::COORD_BITS;
	localparam int NS = mlc_pkg::NUM_SLOTS;

	// one row per slot, all window positions of the slot side by side
	logic [MW-1:0][CB-1:0] hist_q [NS];
	logic [FW-1:0]        fill_q [NS];
	logic [HW-1:0]        head_q [NS];
	logic [1:0]           arm_side_q [NS];
	logic signed [CB-1:0] arm_pos_q [NS];
	logic [7:0]           slot_cd_q [NS];
	logic [7:0]           glob_cd_q;
	logic [15:0]          in_cnt_q, out_cnt_q, occ_q;

	logic                 out_valid_q;
	logic [1:0]           cross_q, side_q;
	logic signed [CB-1:0] smooth_q;

	logic [mlc_pkg::SLOT_W-1:0] s;
	logic [FW-1:0]        old_fill, new_fill, win_len;
	logic [HW-1:0]        old_head;
	logic [1:0]           armed, cls;
	logic [7:0]           cd;
	logic signed [CB-1:0] win [MW];
	logic [FW-1:0]        rank [MW];
	logic signed [CB-1:0] med;
	logic signed [17:0]   lo, hi, m18;
	logic signed [16:0]   dif;
	logic [16:0]          travel;
	logic                 count_ok, is_out;
	logic [1:0]           cross_n, arm_side_n;
	logic                 arm_pos_wr;
	logic                 cd_load;

	assign q_pop   = q_valid && (!out_valid_q || !out_stall);
	assign s       = q_item.slot;
	assign cd_load = q_pop && !q_item.is_tick && cross_n != mlc_pkg::CROSS_NONE;

	always_comb begin
		old_fill = q_item.new_track ? '0 : fill_q[s];
		old_head = q_item.new_track ? '0 : head_q[s];
		armed    = q_item.new_track ? mlc_pkg::SIDE_NONE : arm_side_q[s];
		cd       = q_item.new_track ? 8'd0 : slot_cd_q[s];
		if (cfg.median_window == 4'd0) win_len = 4'd1;
		else if (cfg.median_window > 4'(MW)) win_len = 4'(MW);
		else win_len = cfg.median_window;
		new_fill = (old_fill + 4'd1 > win_len) ? win_len : old_fill + 4'd1;
		win[0] = q_item.pos;
		for (int i = 1; i < MW; i++) win[i] = hist_q[s][HW'(old_head - HW'(i))];
		for (int i = 0; i < MW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < MW; j++)
				if (j != i && 4'(j) < new_fill &&
				    (win[j] < win[i] || (win[j] == win[i] && j < i)))
					rank[i] = rank[i] + 4'd1;
		end
		med = win[0];
		for (int i = 0; i < MW; i++)
			if (4'(i) < new_fill && rank[i] == {1'b0, new_fill[3:1]}) med = win[i];

		m18 = 18'(med);
		lo  = 18'(cfg.line_position) - 18'(signed'({1'b0, cfg.dead_zone}));
		hi  = 18'(cfg.line_position) + 18'(signed'({1'b0, cfg.dead_zone}));
		if (m18 <= lo) cls = mlc_pkg::SIDE_NEG;
		else if (m18 >= hi) cls = mlc_pkg::SIDE_POS;
		else cls = mlc_pkg::SIDE_MID;

		dif    = 17'(med) - 17'(arm_pos_q[s]);
		travel = dif[16] ? 17'(-dif) : 17'(dif);
		count_ok = travel >= {1'b0, cfg.min_travel} && cd == 8'd0 && glob_cd_q == 8'd0;
		is_out = cfg.positive_means_out ? (cls == mlc_pkg::SIDE_POS)
		                                : (cls != mlc_pkg::SIDE_POS);

		cross_n    = mlc_pkg::CROSS_NONE;
		arm_side_n = armed;
		arm_pos_wr = 1'b0;
		if (armed == mlc_pkg::SIDE_NONE) begin
			if (cls != mlc_pkg::SIDE_MID) begin
				arm_side_n = cls;
				arm_pos_wr = 1'b1;
			end
		end else if (cls != mlc_pkg::SIDE_MID && cls != armed) begin
			if (count_ok) begin
				cross_n    = is_out ? mlc_pkg::CROSS_OUT : mlc_pkg::CROSS_IN;
				arm_side_n = cls;
				arm_pos_wr = 1'b1;
			end
		end else if (cls == armed) begin
			arm_pos_wr = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !q_item.is_tick) begin
			hist_q[s][old_head] <= q_item.pos;
			if (arm_pos_wr) arm_pos_q[s] <= med;
		end
		if (q_pop) begin
			cross_q  <= q_item.is_tick ? mlc_pkg::CROSS_NONE : cross_n;
			side_q   <= q_item.is_tick ? mlc_pkg::SIDE_MID : cls;
			smooth_q <= q_item.is_tick ? '0 : med;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				fill_q[i]     <= '0;
				head_q[i]     <= '0;
				arm_side_q[i] <= mlc_pkg::SIDE_NONE;
				slot_cd_q[i]  <= '0;
			end
			glob_cd_q   <= '0;
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (q_pop && q_item.is_tick) begin
				for (int i = 0; i < NS; i++)
					if (slot_cd_q[i] != 8'd0) slot_cd_q[i] <= slot_cd_q[i] - 8'd1;
				if (glob_cd_q != 8'd0) glob_cd_q <= glob_cd_q - 8'd1;
			end else if (q_pop) begin
				fill_q[s]     <= new_fill;
				head_q[s]     <= old_head + 3'd1;
				arm_side_q[s] <= arm_side_n;
				slot_cd_q[s]  <= cd;
				if (cross_n != mlc_pkg::CROSS_NONE) begin
					slot_cd_q[s] <= cfg.track_hold;
					glob_cd_q    <= cfg.global_hold;
				end
				if (cross_n == mlc_pkg::CROSS_OUT) begin
					if (out_cnt_q != 16'hFFFF) out_cnt_q <= out_cnt_q + 16'd1;
					if (occ_q != 16'd0) occ_q <= occ_q - 16'd1;
				end else if (cross_n == mlc_pkg::CROSS_IN) begin
					if (in_cnt_q != 16'hFFFF) in_cnt_q <= in_cnt_q + 16'd1;
					if (occ_q != 16'hFFFF) occ_q <= occ_q + 16'd1;
				end
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign crossing          = cross_q;
	assign side              = side_q;
	assign smoothed_position = smooth_q;
	assign in_total          = in_cnt_q;
	assign out_total         = out_cnt_q;
	assign occupancy         = occ_q;

	`MLC_ASSERT(a_cross_code, !out_valid_q || cross_q != 2'd3)
	`MLC_ASSERT(a_cross_side, !out_valid_q || cross_q == mlc_pkg::CROSS_NONE || side_q != 2'd1)
	`MLC_ASSERT_NEXT(a_in_mono, 1'b1, in_cnt_q >= $past(in_cnt_q))
	`MLC_ASSERT_NEXT(a_cd_set, cd_load, glob_cd_q == $past(cfg.global_hold))
endmodule

[rtl/median_line_crossing_counter.sv]
// Median line crossing counter: top level with APB register file.
// Depends on mlc_pkg, mlc_front, mlc_back.
//
// Input channel: in_valid/in_stall with action, track_slot, position,
// new_track. action 0 is a position sample of a slot, action 1 a frame tick.
// Output channel: out_valid/out_stall, one result per item, in order.
// An accepted item is written into the two entry queue, and its result is
// registered in the result register when the back end pops it from the
// queue, which raises out_valid. One item per cycle is sustained while
// out_stall stays low; the back end finishes an item in the cycle it leaves
// the queue, median and slot state update included.
// When out_stall holds, the result register holds, the queue fills and
// in_stall rises once both queue entries are taken.
// Reset empties the queue, clears all slots (no armed side, zero fill,
// zero cooldowns), counters and loads register defaults; no clearing pass.
// Registers sit at byte address 4*i; write only while the block is idle.
module median_line_crossing_counter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [3:0]         track_slot,
	input  logic signed [15:0] position,
	input  logic               new_track,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         crossing,
	output logic [15:0]        in_total,
	output logic [15:0]        out_total,
	output logic [15:0]        occupancy,
	output logic signed [15:0] smoothed_position,
	output logic [1:0]         side,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	mlc_pkg::cfg_t  cfg_q;
	mlc_pkg::item_t q_item;
	logic           q_valid, q_pop;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_position      <= 16'sd0;
			cfg_q.dead_zone          <= 15'd50;
			cfg_q.min_travel         <= 16'd200;
			cfg_q.track_hold         <= 8'd20;
			cfg_q.global_hold        <= 8'd60;
			cfg_q.median_window      <= 4'd3;
			cfg_q.positive_means_out <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				mlc_pkg::REG_LINE:   cfg_q.line_position      <= pwdata[15:0];
				mlc_pkg::REG_DEAD:   cfg_q.dead_zone          <= pwdata[14:0];
				mlc_pkg::REG_TRAVEL: cfg_q.min_travel         <= pwdata[15:0];
				mlc_pkg::REG_THOLD:  cfg_q.track_hold         <= pwdata[7:0];
				mlc_pkg::REG_GHOLD:  cfg_q.global_hold        <= pwdata[7:0];
				mlc_pkg::REG_WINDOW: cfg_q.median_window      <= pwdata[3:0];
				mlc_pkg::REG_POLAR:  cfg_q.positive_means_out <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mlc_pkg::REG_LINE:   prdata = 32'(cfg_q.line_position);
			mlc_pkg::REG_DEAD:   prdata = 32'(cfg_q.dead_zone);
			mlc_pkg::REG_TRAVEL: prdata = 32'(cfg_q.min_travel);
			mlc_pkg::REG_THOLD:  prdata = 32'(cfg_q.track_hold);
			mlc_pkg::REG_GHOLD:  prdata = 32'(cfg_q.global_hold);
			mlc_pkg::REG_WINDOW: prdata = 32'(cfg_q.median_window);
			mlc_pkg::REG_POLAR:  prdata = 32'(cfg_q.positive_means_out);
			default:             prdata = 32'd0;
		endcase
	end

	mlc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .track_slot(track_slot), .position(position),
		.new_track(new_track),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	mlc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.crossing(crossing), .in_total(in_total), .out_total(out_total),
		.occupancy(occupancy), .smoothed_position(smoothed_position), .side(side)
	);
endmodule

[bench/median_line_crossing_counter_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for median_line_crossing_counter: a queue-fed driver and a
// result monitor, checked against an in-bench model of slot medians and crossings.
// Depends on mlc_pkg and the median_line_crossing_counter RTL.
module median_line_crossing_counter_test;
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_ITEMS = 210;
	localparam int NS = mlc_pkg::NUM_SLOTS;
	localparam int MW = mlc_pkg::MAX_WINDOW;

	typedef struct {
		logic [1:0]         crossing;
		logic [15:0]        in_total;
		logic [15:0]        out_total;
		logic [15:0]        occupancy;
		logic signed [15:0] smoothed;
		logic [1:0]         side;
	} tally_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic action = 0;
	logic [3:0] track_slot = 0;
	logic signed [15:0] position = 0;
	logic new_track = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] crossing;
	logic [15:0] in_total, out_total, occupancy;
	logic signed [15:0] smoothed_position;
	logic [1:0] side;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;

	median_line_crossing_counter i_dut (.*);

	// model state
	mlc_pkg::cfg_t cfg;
	logic signed [15:0] hist [NS][MW];
	int fill [NS];
	int head [NS];
	logic [1:0] trk_side [NS];
	logic signed [15:0] trk_pos [NS];
	int slot_cd [NS];
	int shared_cd, in_cnt, out_cnt, inside_cnt;

	mlc_pkg::item_t pending_items [$];
	tally_t awaited_results [$];
	int err_n = 0;
	bit send_idle = 0, recv_idle = 0;
	int hold_req = 0, hold_seen = 0, hold_left = 0;
	int send_gap = 0, recv_gap = 0, quiet_cycles = 0;
	int walker [NS];
	bit walk_up [NS];

	initial forever #5 clk = ~clk;

	task automatic clear_slot(input int s);
		fill[s] = 0;
		head[s] = 0;
		trk_side[s] = mlc_pkg::SIDE_NONE;
		trk_pos[s] = 0;
		slot_cd[s] = 0;
	endtask

	task automatic queue_item(input mlc_pkg::item_t it);
		pending_items = {pending_items, it};
	endtask

	function automatic logic [1:0] class_of(input int v);
		int dz;
		dz = cfg.dead_zone;
		if (v <= int'(cfg.line_position) - dz) return mlc_pkg::SIDE_NEG;
		if (v >= int'(cfg.line_position) + dz) return mlc_pkg::SIDE_POS;
		return mlc_pkg::SIDE_MID;
	endfunction

	task automatic predict_item(input mlc_pkg::item_t it);
		tally_t r;
		int s, w, i, j, v, idx, travel;
		int vals [MW];
		bit is_out;
		r.crossing = mlc_pkg::CROSS_NONE;
		r.smoothed = 0;
		r.side = mlc_pkg::SIDE_MID;
		if (it.is_tick) begin
			for (s = 0; s < NS; s++)
				if (slot_cd[s] > 0) slot_cd[s]--;
			if (shared_cd > 0) shared_cd--;
		end else begin
			s = it.slot;
			w = cfg.median_window;
			if (w < 1) w = 1;
			if (w > MW) w = MW;
			if (it.new_track) clear_slot(s);
			hist[s][head[s]] = it.pos;
			head[s] = (head[s] + 1) % MW;
			fill[s] = fill[s] + 1;
			if (fill[s] > w) fill[s] = w;
			idx = head[s];
			for (i = 0; i < fill[s]; i++) begin
				idx = (idx + MW - 1) % MW;
				vals[i] = hist[s][idx];
			end
			for (i = 1; i < fill[s]; i++) begin
				v = vals[i];
				j = i;
				while (j > 0 && vals[j-1] > v) begin
					vals[j] = vals[j-1];
					j--;
				end
				vals[j] = v;
			end
			v = vals[fill[s] / 2];
			r.smoothed = 16'(v);
			r.side = class_of(v);
			if (trk_side[s] == mlc_pkg::SIDE_NONE) begin
				if (r.side != mlc_pkg::SIDE_MID) begin
					trk_side[s] = r.side;
					trk_pos[s] = 16'(v);
				end
			end else if (r.side != mlc_pkg::SIDE_MID && r.side != trk_side[s]) begin
				travel = v - int'(trk_pos[s]);
				if (travel < 0) travel = -travel;
				if (travel >= int'(cfg.min_travel) && slot_cd[s] == 0 && shared_cd == 0) begin
					is_out = cfg.positive_means_out ? (r.side == mlc_pkg::SIDE_POS)
					                                : (r.side != mlc_pkg::SIDE_POS);
					if (is_out) begin
						r.crossing = mlc_pkg::CROSS_OUT;
						if (out_cnt < 65535) out_cnt++;
						if (inside_cnt > 0) inside_cnt--;
					end else begin
						r.crossing = mlc_pkg::CROSS_IN;
						if (in_cnt < 65535) in_cnt++;
						if (inside_cnt < 65535) inside_cnt++;
					end
					slot_cd[s] = cfg.track_hold;
					shared_cd = cfg.global_hold;
					trk_side[s] = r.side;
					trk_pos[s] = 16'(v);
				end
			end else if (r.side == trk_side[s]) begin
				trk_pos[s] = 16'(v);
			end
		end
		r.in_total = 16'(in_cnt);
		r.out_total = 16'(out_cnt);
		r.occupancy = 16'(inside_cnt);
		awaited_results = {awaited_results, r};
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_n++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_item(mlc_pkg::item_t'{action, track_slot, position, new_track});
				send_gap = send_idle ? $urandom_range(0, 10) : 0;
			end
			if (in_valid && in_stall) begin
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 0;
			end else if (pending_items.size() > 0) begin
				mlc_pkg::item_t it;
				it = pending_items[0];
				pending_items.delete(0);
				action <= it.is_tick;
				track_slot <= it.slot;
				position <= it.pos;
				new_track <= it.new_track;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result with nothing awaited");
					err_n++;
				end else begin
					tally_t r;
					r = awaited_results[0];
					awaited_results.delete(0);
					check_field("crossing", r.crossing, crossing);
					check_field("in_total", r.in_total, in_total);
					check_field("out_total", r.out_total, out_total);
					check_field("occupancy", r.occupancy, occupancy);
					check_field("smoothed_position", r.smoothed, smoothed_position);
					check_field("side", r.side, side);
				end
				recv_gap = recv_idle ? $urandom_range(0, 10) : 0;
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles = 0;
		else if (awaited_results.size() > 0 || pending_items.size() > 0 || in_valid)
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("median_line_crossing_counter_test: done, errors");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			mlc_pkg::REG_LINE:   cfg.line_position = v[15:0];
			mlc_pkg::REG_DEAD:   cfg.dead_zone = v[14:0];
			mlc_pkg::REG_TRAVEL: cfg.min_travel = v[15:0];
			mlc_pkg::REG_THOLD:  cfg.track_hold = v[7:0];
			mlc_pkg::REG_GHOLD:  cfg.global_hold = v[7:0];
			mlc_pkg::REG_WINDOW: cfg.median_window = v[3:0];
			mlc_pkg::REG_POLAR:  cfg.positive_means_out = v[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic mlc_pkg::item_t sample(input int s, input int p, input bit fresh);
		mlc_pkg::item_t it;
		it.is_tick = 1'b0;
		it.slot = 4'(s);
		it.pos = 16'(p);
		it.new_track = fresh;
		return it;
	endfunction

	function automatic mlc_pkg::item_t tick();
		mlc_pkg::item_t it;
		it.is_tick = 1'b1;
		it.slot = 4'($urandom);
		it.pos = 16'($urandom);
		it.new_track = 1'($urandom);
		return it;
	endfunction

	// mostly slots walking back and forth over the line, some noise
	function automatic mlc_pkg::item_t random_item();
		int s, p, ln;
		if ($urandom_range(0, 3) == 0) return tick();
		s = $urandom_range(0, NS - 1);
		if ($urandom_range(0, 9) == 0)
			return sample(s, int'($signed(16'($urandom))), $urandom_range(0, 1) == 1);
		ln = cfg.line_position;
		if (walker[s] > ln + 800) walk_up[s] = 0;
		if (walker[s] < ln - 800) walk_up[s] = 1;
		p = walker[s] + (walk_up[s] ? 1 : -1) * int'($urandom_range(0, 200))
		    + int'($urandom_range(0, 60)) - 30;
		if (p > 32767) p = 32767;
		if (p < -32768) p = -32768;
		walker[s] = p;
		return sample(s, p, $urandom_range(0, 29) == 0);
	endfunction

	initial begin
		int ph, n;
		cfg = '{16'sd0, 15'd50, 16'd200, 8'd20, 8'd60, 4'd3, 1'b1};
		for (n = 0; n < NS; n++) begin
			clear_slot(n);
			walker[n] = 0;
			walk_up[n] = (n % 2) == 1;
		end
		shared_cd = 0;
		in_cnt = 0;
		out_cnt = 0;
		inside_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: arm, cross out at empty room, blocked return, ticks, extremes
		queue_item(sample(0, -1000, 1'b1));
		queue_item(sample(0, -1000, 1'b0));
		queue_item(sample(0, 1000, 1'b0));
		queue_item(sample(0, 1000, 1'b0));
		queue_item(sample(0, -1000, 1'b0));
		queue_item(sample(0, -1000, 1'b0));
		queue_item(tick());
		queue_item(sample(1, 20, 1'b1));
		queue_item(sample(1, 50, 1'b0));
		queue_item(sample(1, -50, 1'b0));
		queue_item(sample(2, -32768, 1'b1));
		queue_item(sample(2, 32767, 1'b0));
		queue_item(sample(2, 32767, 1'b0));
		queue_item(sample(15, 32767, 1'b1));
		queue_item(sample(15, 0, 1'b0));
		queue_item(sample(15, -32768, 1'b0));
		queue_item(tick());
		wait_drained();
		reg_write(mlc_pkg::REG_THOLD, 0);
		reg_write(mlc_pkg::REG_GHOLD, 0);
		reg_write(mlc_pkg::REG_DEAD, 0);
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		queue_item(sample(3, 0, 1'b1));
		queue_item(sample(3, 300, 1'b0));
		queue_item(sample(3, 300, 1'b0));
		queue_item(sample(3, -300, 1'b0));
		queue_item(sample(3, -300, 1'b0));
		wait_drained();

		for (ph = 0; ph < 7; ph++) begin
			case (ph)
				1: begin
					reg_write(mlc_pkg::REG_LINE, 32'h0000_8000);
					reg_write(mlc_pkg::REG_DEAD, 0);
					reg_write(mlc_pkg::REG_TRAVEL, 0);
					reg_write(mlc_pkg::REG_THOLD, 0);
					reg_write(mlc_pkg::REG_GHOLD, 0);
					reg_write(mlc_pkg::REG_WINDOW, 0);
					reg_write(mlc_pkg::REG_POLAR, 0);
				end
				2: begin
					reg_write(mlc_pkg::REG_LINE, 32'h0000_7FFF);
					reg_write(mlc_pkg::REG_DEAD, 32'h7FFF);
					reg_write(mlc_pkg::REG_TRAVEL, 32'hFFFF);
					reg_write(mlc_pkg::REG_THOLD, 255);
					reg_write(mlc_pkg::REG_GHOLD, 255);
					reg_write(mlc_pkg::REG_WINDOW, 15);
					reg_write(mlc_pkg::REG_POLAR, 1);
				end
				default: begin
					reg_write(mlc_pkg::REG_LINE, $urandom_range(0, 4000) - 2000);
					reg_write(mlc_pkg::REG_DEAD, $urandom_range(0, 150));
					reg_write(mlc_pkg::REG_TRAVEL, $urandom_range(0, 400));
					reg_write(mlc_pkg::REG_THOLD, $urandom_range(0, 6));
					reg_write(mlc_pkg::REG_GHOLD, $urandom_range(0, 4));
					reg_write(mlc_pkg::REG_WINDOW, $urandom_range(0, 15));
					reg_write(mlc_pkg::REG_POLAR, $urandom_range(0, 1));
				end
			endcase
			send_idle = (ph % 2) == 1;
			recv_idle = ((ph / 2) % 2) == 1;
			if (ph == 3) begin
				send_idle = 0;
				hold_req++;
			end
			for (n = 0; n < PHASE_ITEMS; n++)
				queue_item(random_item());
			wait_drained();
		end

		if (err_n == 0)
			$display("median_line_crossing_counter_test: done, clean");
		else
			$display("median_line_crossing_counter_test: done, errors");
		$finish;
	end
endmodule
